### rtl/acs_pkg.sv
// Shared types and constants for the accelerometer step counter.
package acs_pkg;

  // Request kinds on the input channel
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TOGGLE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOW_SQ   = 2'd0;
  localparam logic [1:0] CFG_HIGH_SQ  = 2'd1;
  localparam logic [1:0] CFG_REFRACT  = 2'd2;

  // Configuration reset values
  localparam logic [33:0] LOW_SQ_RESET  = 34'd697925;
  localparam logic [33:0] HIGH_SQ_RESET = 34'd17447329;
  localparam logic [7:0]  REFRACT_RESET = 8'd15;

  // Saturation limits
  localparam logic [15:0] STEP_MAX   = 16'hFFFF;
  localparam logic [7:0]  PERIOD_MAX = 8'hFF;

  // Operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_SAMPLE_ON,
    OP_SAMPLE_OFF,
    OP_TOGGLE,
    OP_CLEAR,
    OP_NOP
  } acs_op_t;

  typedef struct packed {
    acs_op_t     op;
    logic        counting_on;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [15:0] mag_z;
  } acs_item_t;

  typedef struct packed {
    logic [33:0] low_sq;
    logic [33:0] high_sq;
    logic [7:0]  refractory;
  } acs_cfg_t;

  typedef struct packed {
    logic [15:0] step_count;
    logic        counting_on;
    logic        step_detected;
  } acs_result_t;

endpackage

### rtl/accel_step_counter_top.sv
// Top level of the accelerometer step counter: config registers, queues, front and back end.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | push / full            | in_kind, in_accel_x, in_accel_y, in_accel_z
//  result   | pop / empty            | out_step_count, out_counting_on,
//           |                        | out_step_detected
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle sustained while the result queue keeps draining; each result
// passes the middle queue, the square stage and the sum stage into the output queue
// before it reaches the result ports, where it can be popped. The step/period update
// in the back end sets the rate.
// Synchronous active-low reset clears queues, counters and config to defaults.
// A stalled result queue holds the back end; the middle queue then fills and
// raises full. cfg_ready is always high.
module accel_step_counter_top #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        out_step_count,
  output logic               out_counting_on,
  output logic               out_step_detected,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [33:0]        cfg_data
);
  import acs_pkg::*;

  acs_cfg_t    cfg_r;
  acs_item_t   front_item, mid_item;
  acs_result_t back_res, out_res;
  logic        accept;
  logic        mid_empty, mid_pop;
  logic        res_full, res_push;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_sq     <= LOW_SQ_RESET;
      cfg_r.high_sq    <= HIGH_SQ_RESET;
      cfg_r.refractory <= REFRACT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOW_SQ:  cfg_r.low_sq     <= cfg_data;
        CFG_HIGH_SQ: cfg_r.high_sq    <= cfg_data;
        CFG_REFRACT: cfg_r.refractory <= cfg_data[7:0];
        default:     cfg_r            <= cfg_r;
      endcase
    end
  end

  acs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .kind    (in_kind),
    .accel_x (in_accel_x),
    .accel_y (in_accel_y),
    .accel_z (in_accel_z),
    .item    (front_item)
  );

  acs_fifo #(
    .WIDTH ($bits(acs_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  acs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (mid_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  acs_fifo #(
    .WIDTH ($bits(acs_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_step_count    = out_res.step_count;
  assign out_counting_on   = out_res.counting_on;
  assign out_step_detected = out_res.step_detected;

  // a step can only be seen while counting is on
  a_step_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_step_detected) |-> out_counting_on)
    else $error("step reported with counting off");

  // a detected step leaves a nonzero count
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_step_detected) |-> (out_step_count != 16'd0))
    else $error("step reported with zero count");

  // no results survive a reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule

### rtl/acs_fifo.sv
// Small register-based FIFO used between front and back end and at the output.
module acs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/acs_front.sv
// Front end: decodes requests, tracks counting enable and the stored reading.
module acs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         kind,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output acs_pkg::acs_item_t item
);
  import acs_pkg::*;

  logic               enabled_r, enabled_nxt;
  logic signed [15:0] prev_x_r, prev_y_r, prev_z_r;
  logic               store_prev;

  // absolute difference of two signed readings, always fits 16 bits unsigned
  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    logic signed [16:0] m;
    d = {a[15], a} - {b[15], b};
    m = d[16] ? -d : d;
    return m[15:0];
  endfunction

  // classify the request
  always_comb begin
    enabled_nxt      = enabled_r;
    store_prev       = 1'b0;
    item.op          = OP_NOP;
    item.mag_x       = abs_diff(accel_x, prev_x_r);
    item.mag_y       = abs_diff(accel_y, prev_y_r);
    item.mag_z       = abs_diff(accel_z, prev_z_r);
    unique case (kind)
      KIND_SAMPLE: begin
        if (enabled_r) begin
          item.op    = OP_SAMPLE_ON;
          store_prev = 1'b1;
        end else begin
          item.op    = OP_SAMPLE_OFF;
        end
      end
      KIND_TOGGLE: begin
        item.op     = OP_TOGGLE;
        enabled_nxt = !enabled_r;
      end
      KIND_CLEAR: begin
        item.op = OP_CLEAR;
      end
      default: begin
        item.op = OP_NOP;
      end
    endcase
    item.counting_on = enabled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      prev_z_r  <= '0;
    end else if (accept) begin
      enabled_r <= enabled_nxt;
      if (store_prev) begin
        prev_x_r <= accel_x;
        prev_y_r <= accel_y;
        prev_z_r <= accel_z;
      end
    end
  end

endmodule

### rtl/acs_back.sv
// Back end: squares, sums, window check and step/period bookkeeping.
module acs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acs_pkg::acs_cfg_t    cfg,
  input  acs_pkg::acs_item_t   item,
  input  logic                 item_empty,
  output logic                 item_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output acs_pkg::acs_result_t res
);
  import acs_pkg::*;

  // square stage
  logic        sq_valid_r;
  acs_op_t     sq_op_r;
  logic        sq_on_r;
  logic [31:0] sq_x_r, sq_y_r, sq_z_r;

  // sum stage
  logic        sum_valid_r;
  acs_op_t     sum_op_r;
  logic        sum_on_r;
  logic [33:0] sum_r;

  // architectural counters
  logic [15:0] steps_r, steps_nxt;
  logic [7:0]  periods_r, periods_nxt;
  logic        detected;
  logic        in_window;
  logic [7:0]  periods_inc;
  logic        advance;

  // whole pipe holds while the last stage cannot hand off its result
  assign advance  = !(sum_valid_r && res_full);
  assign item_pop = advance && !item_empty;
  assign res_push = sum_valid_r && !res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
    end else if (advance) begin
      sq_valid_r  <= !item_empty;
      sum_valid_r <= sq_valid_r;
    end
  end

  // payload of both stages
  always_ff @(posedge clk) begin
    if (advance) begin
      sq_op_r  <= item.op;
      sq_on_r  <= item.counting_on;
      sq_x_r   <= item.mag_x * item.mag_x;
      sq_y_r   <= item.mag_y * item.mag_y;
      sq_z_r   <= item.mag_z * item.mag_z;
      sum_op_r <= sq_op_r;
      sum_on_r <= sq_on_r;
      sum_r    <= {2'b00, sq_x_r} + {2'b00, sq_y_r} + {2'b00, sq_z_r};
    end
  end

  // window check and counter update
  assign in_window   = (sum_r > cfg.low_sq) && (sum_r < cfg.high_sq);
  assign periods_inc = (periods_r == PERIOD_MAX) ? periods_r : periods_r + 1'b1;

  always_comb begin
    steps_nxt   = steps_r;
    periods_nxt = periods_r;
    detected    = 1'b0;
    unique case (sum_op_r)
      OP_SAMPLE_ON: begin
        periods_nxt = periods_inc;
        if (in_window && (periods_inc > cfg.refractory)) begin
          detected    = 1'b1;
          periods_nxt = '0;
          if (steps_r != STEP_MAX) begin
            steps_nxt = steps_r + 1'b1;
          end
        end
      end
      OP_SAMPLE_OFF: begin
        periods_nxt = periods_inc;
      end
      OP_CLEAR: begin
        steps_nxt = '0;
      end
      default: begin
        steps_nxt = steps_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r   <= '0;
      periods_r <= '0;
    end else if (res_push) begin
      steps_r   <= steps_nxt;
      periods_r <= periods_nxt;
    end
  end

  assign res.step_count    = steps_nxt;
  assign res.counting_on   = sum_on_r;
  assign res.step_detected = detected;

endmodule
